/* rtl/sftfs_pkg.sv */
// Shared types and constants for the successor take-from-set block.
// No dependencies; imported by the store, the controller and the top level.
package sftfs_pkg;

  // Width of a value field on the ports
  localparam int VAL_W = 12;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Reset value of the limit register
  localparam logic [VAL_W-1:0] MAX_VALUE_RESET = 12'd4095;

  // Strobes from the controller to the block store
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  // Result of one query, from the controller to the output register
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } res_t;

endpackage

/* rtl/successor_take_from_set.sv */
// Top level of the successor take-from-set block: limit register, output
// register, sftfs_ctrl and sftfs_store. Uses sftfs_pkg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | req_type, item_value
//   out     | output    | out_valid / out_ready| taken_value, found
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (max_value)
//
// One request is in work at a time. A stored insert passes S_DEC and S_INS,
// an ignored one S_DEC only. A query passes S_DEC and then: S_RES when no
// block is left to search; S_QRD, S_RES after one block read; S_QRD, S_NEXT,
// S_RES when the first block holds only smaller values and no later block
// qualifies; S_QRD, S_NEXT, S_QRD, S_RES when a second block is read. Each
// block visit is a read and a check-and-write. Reset clears the store at once
// through per-row valid bits; no sweep. A waiting result in the output register
// stalls a query only when its result is ready; cfg_ready is always high.
module successor_take_from_set
  import sftfs_pkg::*;
#(
  parameter int VALUE_SPACE = 4096,
  parameter int BLOCK_SIZE  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [VAL_W-1:0] item_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] taken_value,
  output logic             found,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_data
);

  localparam int NUM_BLOCKS = VALUE_SPACE / BLOCK_SIZE;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);

  logic [VAL_W-1:0]      max_value;
  mem_cmd_t              cmd;
  logic [BLK_W-1:0]      mem_addr;
  logic [BLOCK_SIZE-1:0] wr_word, rd_word;
  logic [CNT_W-1:0]      wr_count, rd_count;
  logic [NUM_BLOCKS-1:0] summary;
  logic                  res_valid, res_ready;
  res_t                  res;

  // Limit register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_valid) begin
      max_value <= cfg_data;
    end
  end

  sftfs_ctrl #(
    .VALUE_SPACE (VALUE_SPACE),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .item_value (item_value),
    .max_value  (max_value),
    .cmd        (cmd),
    .mem_addr   (mem_addr),
    .wr_word    (wr_word),
    .wr_count   (wr_count),
    .rd_word    (rd_word),
    .rd_count   (rd_count),
    .summary    (summary),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  sftfs_store #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .addr     (mem_addr),
    .wr_word  (wr_word),
    .wr_count (wr_count),
    .rd_word  (rd_word),
    .rd_count (rd_count),
    .summary  (summary)
  );

  // Output register: hold a result until taken
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      taken_value <= res.value;
      found       <= res.found;
    end
  end

endmodule

/* rtl/sftfs_store.sv */
// Block store: presence words and member counts in two synchronous memories,
// one row per block, plus row-valid and non-empty summary bits. Uses sftfs_pkg.
module sftfs_store
  import sftfs_pkg::*;
#(
  parameter int NUM_BLOCKS = 64,
  parameter int BLOCK_SIZE = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mem_cmd_t                      cmd,
  input  logic [$clog2(NUM_BLOCKS)-1:0] addr,
  input  logic [BLOCK_SIZE-1:0]         wr_word,
  input  logic [$clog2(BLOCK_SIZE+1)-1:0] wr_count,
  output logic [BLOCK_SIZE-1:0]         rd_word,
  output logic [$clog2(BLOCK_SIZE+1)-1:0] rd_count,
  output logic [NUM_BLOCKS-1:0]         summary
);

  localparam int CNT_W = $clog2(BLOCK_SIZE + 1);

  logic [BLOCK_SIZE-1:0] word_mem  [NUM_BLOCKS];
  logic [CNT_W-1:0]      count_mem [NUM_BLOCKS];
  logic [BLOCK_SIZE-1:0] word_q;
  logic [CNT_W-1:0]      count_q;
  logic [NUM_BLOCKS-1:0] row_valid;
  logic                  rd_valid;

  // Memory arrays: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      word_mem[addr]  <= wr_word;
      count_mem[addr] <= wr_count;
    end
    if (cmd.rd) begin
      word_q  <= word_mem[addr];
      count_q <= count_mem[addr];
    end
  end

  // Track written rows and non-empty blocks; reset clears both at once
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      summary   <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.wr) begin
        row_valid[addr] <= 1'b1;
        summary[addr]   <= (wr_count != '0);
      end
      if (cmd.rd) begin
        rd_valid <= row_valid[addr];
      end
    end
  end

  // A row never written since reset reads as empty
  assign rd_word  = rd_valid ? word_q  : '0;
  assign rd_count = rd_valid ? count_q : '0;

endmodule

/* rtl/sftfs_ctrl.sv */
// Request sequencer: decodes a request, picks a block from the summary bits,
// reads a row of the store per block visit and writes back a changed row. Uses sftfs_pkg.
module sftfs_ctrl
  import sftfs_pkg::*;
#(
  parameter int VALUE_SPACE = 4096,
  parameter int BLOCK_SIZE  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [VAL_W-1:0]              item_value,
  input  logic [VAL_W-1:0]              max_value,
  output mem_cmd_t                      cmd,
  output logic [$clog2(VALUE_SPACE/BLOCK_SIZE)-1:0] mem_addr,
  output logic [BLOCK_SIZE-1:0]         wr_word,
  output logic [$clog2(BLOCK_SIZE+1)-1:0] wr_count,
  input  logic [BLOCK_SIZE-1:0]         rd_word,
  input  logic [$clog2(BLOCK_SIZE+1)-1:0] rd_count,
  input  logic [VALUE_SPACE/BLOCK_SIZE-1:0] summary,
  output logic                          res_valid,
  input  logic                          res_ready,
  output res_t                          res
);

  localparam int NUM_BLOCKS = VALUE_SPACE / BLOCK_SIZE;
  localparam int AW         = $clog2(VALUE_SPACE);
  localparam int OFF_W      = $clog2(BLOCK_SIZE);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
  localparam int WV         = (AW > VAL_W) ? AW : VAL_W;
  localparam int CAP_INT    = (VALUE_SPACE - 1 > 4095) ? 4095 : VALUE_SPACE - 1;
  localparam logic [VAL_W-1:0] CAP = VAL_W'(CAP_INT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_QRD  = 3'd3;
  localparam logic [2:0] S_NEXT = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;

  logic [2:0]       state, state_next;
  logic             req_q;
  logic [VAL_W-1:0] val_q;
  logic [BLK_W-1:0] start_blk, limit_blk, cur_blk;
  logic [OFF_W-1:0] start_off, limit_off, ins_off;
  logic             res_found;
  logic [VAL_W-1:0] res_value;

  // Decode terms of the latched request
  logic [VAL_W-1:0] limit;
  logic [VAL_W:0]   start;
  logic             no_room;
  logic [BLK_W-1:0] s_blk, l_blk, i_blk;
  logic [OFF_W-1:0] s_off, l_off, i_off;
  logic             ins_ok;

  always_comb begin
    limit   = (max_value > CAP) ? CAP : max_value;
    start   = {1'b0, val_q} + {{VAL_W{1'b0}}, 1'b1};
    no_room = start > {1'b0, limit};
    s_blk   = BLK_W'(WV'(start[VAL_W-1:0]) >> OFF_W);
    s_off   = OFF_W'(WV'(start[VAL_W-1:0]));
    l_blk   = BLK_W'(WV'(limit) >> OFF_W);
    l_off   = OFF_W'(WV'(limit));
    i_blk   = BLK_W'(WV'(val_q) >> OFF_W);
    i_off   = OFF_W'(WV'(val_q));
    ins_ok  = (val_q <= max_value) && (int'(val_q) < VALUE_SPACE);
  end

  // Lowest non-empty block at or above the search floor (strictly above in S_NEXT)
  logic [BLK_W-1:0]      lo_blk, hi_blk, pick_blk;
  logic                  strict;
  logic [NUM_BLOCKS-1:0] cand;
  logic                  pick_ok;

  always_comb begin
    lo_blk   = (state == S_DEC) ? s_blk : start_blk;
    hi_blk   = (state == S_DEC) ? l_blk : limit_blk;
    strict   = (state == S_NEXT);
    pick_blk = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      cand[i] = summary[i] &&
                ((BLK_W'(i) > lo_blk) || (!strict && (BLK_W'(i) == lo_blk)));
    end
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_blk = BLK_W'(i);
      end
    end
    pick_ok = (|cand) && (pick_blk <= hi_blk);
  end

  // Lowest present bit in the read row, inside the search window
  logic [BLOCK_SIZE-1:0] win;
  logic [OFF_W-1:0]      pos;
  logic                  win_hit;

  always_comb begin
    pos = '0;
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      win[i] = rd_word[i] &&
               ((cur_blk != start_blk) || (OFF_W'(i) >= start_off)) &&
               ((cur_blk != limit_blk) || (OFF_W'(i) <= limit_off));
    end
    for (int i = BLOCK_SIZE - 1; i >= 0; i--) begin
      if (win[i]) begin
        pos = OFF_W'(i);
      end
    end
    win_hit = |win;
  end

  // Next state and store access
  always_comb begin
    state_next = state;
    cmd        = '0;
    mem_addr   = cur_blk;
    wr_word    = rd_word;
    wr_count   = rd_count;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        if (req_q == REQ_INSERT) begin
          if (ins_ok) begin
            cmd.rd     = 1'b1;
            mem_addr   = i_blk;
            state_next = S_INS;
          end else begin
            state_next = S_IDLE;
          end
        end else if (no_room || !pick_ok) begin
          state_next = S_RES;
        end else begin
          cmd.rd     = 1'b1;
          mem_addr   = pick_blk;
          state_next = S_QRD;
        end
      end
      S_INS: begin
        // set the bit unless it is already present
        if (!rd_word[ins_off]) begin
          cmd.wr   = 1'b1;
          wr_word  = rd_word | (BLOCK_SIZE'(1) << ins_off);
          wr_count = rd_count + CNT_W'(1);
        end
        state_next = S_IDLE;
      end
      S_QRD: begin
        if (win_hit) begin
          cmd.wr     = 1'b1;
          wr_word    = rd_word & ~(BLOCK_SIZE'(1) << pos);
          wr_count   = rd_count - CNT_W'(1);
          state_next = S_RES;
        end else if (cur_blk == start_blk) begin
          // first block held only smaller values: search past it
          state_next = S_NEXT;
        end else begin
          state_next = S_RES;
        end
      end
      S_NEXT: begin
        if (pick_ok) begin
          cmd.rd     = 1'b1;
          mem_addr   = pick_blk;
          state_next = S_QRD;
        end else begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request and search registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_q <= req_type;
          val_q <= item_value;
        end
      end
      S_DEC: begin
        start_blk <= s_blk;
        start_off <= s_off;
        limit_blk <= l_blk;
        limit_off <= l_off;
        ins_off   <= i_off;
        cur_blk   <= (req_q == REQ_INSERT) ? i_blk : pick_blk;
        res_found <= 1'b0;
        res_value <= '0;
      end
      S_QRD: begin
        if (win_hit) begin
          res_found <= 1'b1;
          res_value <= VAL_W'(WV'({cur_blk, pos}));
        end
      end
      S_NEXT: begin
        cur_blk <= pick_blk;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RES);
  assign res.found = res_found;
  assign res.value = res_value;

endmodule

/* rtl/sftfs_check.sv */
// Port checker for the successor take-from-set block, bound to the top level.
// Sees only the top-level ports; no package needed.
module sftfs_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] taken_value,
  input logic        found
);

  // One request in work at a time: no accept in the cycle after an accept
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in work");

  // A miss reports a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (taken_value == 12'd0))
    else $error("miss result carries a nonzero value");

  // A taken value is a strict successor, so never zero
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (taken_value != 12'd0))
    else $error("hit result carries value zero");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(taken_value) && $stable(found)))
    else $error("stalled result changed");

endmodule

bind successor_take_from_set sftfs_check u_sftfs_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .taken_value (taken_value),
  .found       (found)
);
